/* hdl/bplc_pkg.sv */
package bplc_pkg;

	localparam int unsigned TICK_W = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned COUNT_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_ACTION_ENABLED = 3'd0,
		REG_LONG_ACTION_ENABLED  = 3'd1,
		REG_SEND_RELEASE         = 3'd2,
		REG_PRESS_ON_RELEASE     = 3'd3,
		REG_LONG_PRESS_TICKS     = 3'd4
	} cfg_reg_t;

	localparam logic TGT_SHORT = 1'b0;
	localparam logic TGT_LONG = 1'b1;
	localparam logic EDGE_PRESS = 1'b0;
	localparam logic EDGE_RELEASE = 1'b1;

	typedef struct packed {
		logic target;
		logic edge_kind;
		logic last;
	} evt_t;

	localparam logic [TICK_W-1:0] LONG_PRESS_TICKS_RST = TICK_W'(250);

endpackage

/* hdl/button_long_press_classifier_unit.sv */
// Button press classifier. Each input word is one button sample (active, changed, level,
// tick stamp); each output word is one event (short or long target, press or release edge)
// with last_event marking the final event of its sample. A sample enters the input register,
// is classified from that register and its zero, one or two events drop into a two-word
// output queue whose head drives the event outputs. A new sample is taken every cycle while
// the queue has room; a sample that gives two events occupies the output for both in turn,
// so sustained rate is set by the output port: one event per cycle while out_stall is low.
// In long-press mode the press time is stamped and the hold is measured modulo 2^32 against
// long_press_ticks. Registers are written on the cfg port; indexes past the list are ignored.
module button_long_press_classifier_unit
	import bplc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 sample_active,
	input  logic                 sample_changed,
	input  logic                 button_level,
	input  logic [TICK_W-1:0]    now_ticks,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 event_target,
	output logic                 event_edge,
	output logic                 last_event
);

	logic              short_en_q;
	logic              long_en_q;
	logic              send_rel_q;
	logic              por_q;
	logic [TICK_W-1:0] long_ticks_q;

	logic              valid_s1;
	logic              active_s1;
	logic              changed_s1;
	logic              level_s1;
	logic [TICK_W-1:0] now_s1;

	logic [TICK_W-1:0] stamp_q;
	logic              timing_valid_q;
	logic              long_active_q;

	evt_t              slot_q [QUEUE_DEPTH];
	logic [COUNT_W-1:0] count_q;

	logic [TICK_W-1:0] stamp_d;
	logic              timing_valid_d;
	logic              long_active_d;
	logic [TICK_W-1:0] held;
	evt_t              ev0;
	evt_t              ev1;
	logic [COUNT_W-1:0] n_ev;

	logic              pop;
	logic              advance;
	logic              in_take;
	logic [COUNT_W-1:0] cnt_pop;
	logic [COUNT_W:0]  fill_sum;
	evt_t              slot_d [QUEUE_DEPTH];
	logic [COUNT_W-1:0] count_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_en_q <= 1'b1;
			long_en_q <= 1'b0;
			send_rel_q <= 1'b1;
			por_q <= 1'b0;
			long_ticks_q <= LONG_PRESS_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SHORT_ACTION_ENABLED: short_en_q <= cfg_data[0];
				REG_LONG_ACTION_ENABLED:  long_en_q <= cfg_data[0];
				REG_SEND_RELEASE:         send_rel_q <= cfg_data[0];
				REG_PRESS_ON_RELEASE:     por_q <= cfg_data[0];
				REG_LONG_PRESS_TICKS:     long_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify the registered sample against the state it would see
	always_comb begin
		stamp_d = stamp_q;
		timing_valid_d = timing_valid_q;
		long_active_d = long_active_q;
		ev0 = '0;
		ev1 = '0;
		n_ev = '0;
		held = '0;
		if (active_s1 && short_en_q) begin
			if (!long_en_q) begin
				if (changed_s1) begin
					if (level_s1 != por_q) begin
						ev0 = '{target: TGT_SHORT, edge_kind: EDGE_PRESS, last: 1'b0};
						n_ev = COUNT_W'(1);
					end else if (!level_s1 && send_rel_q) begin
						ev0 = '{target: TGT_SHORT, edge_kind: EDGE_RELEASE, last: 1'b0};
						n_ev = COUNT_W'(1);
					end
				end
			end else begin
				if (changed_s1 && level_s1) begin
					stamp_d = now_s1;
					timing_valid_d = 1'b1;
				end else if (changed_s1 && !level_s1) begin
					if (long_active_q) begin
						if (send_rel_q) begin
							ev0 = '{target: TGT_LONG, edge_kind: EDGE_RELEASE, last: 1'b0};
							n_ev = COUNT_W'(1);
						end
					end else begin
						ev0 = '{target: TGT_SHORT, edge_kind: EDGE_PRESS, last: 1'b0};
						n_ev = COUNT_W'(1);
						if (send_rel_q) begin
							ev1 = '{target: TGT_SHORT, edge_kind: EDGE_RELEASE, last: 1'b0};
							n_ev = COUNT_W'(2);
						end
					end
					timing_valid_d = 1'b0;
					long_active_d = 1'b0;
				end
				held = now_s1 - stamp_d;
				// a level-high sample never carries a release event, so slot 0 is free here
				if (level_s1 && timing_valid_d && !long_active_d && held >= long_ticks_q) begin
					long_active_d = 1'b1;
					ev0 = '{target: TGT_LONG, edge_kind: EDGE_PRESS, last: 1'b0};
					n_ev = COUNT_W'(1);
				end
			end
		end
		if (n_ev == COUNT_W'(1)) begin
			ev0.last = 1'b1;
		end
		if (n_ev == COUNT_W'(2)) begin
			ev1.last = 1'b1;
		end
	end

	// output queue: slot 0 is the head
	assign out_valid = (count_q != '0);
	assign pop = out_valid && !out_stall;
	assign cnt_pop = count_q - COUNT_W'(pop);
	assign fill_sum = {1'b0, cnt_pop} + {1'b0, n_ev};
	assign advance = valid_s1 && (fill_sum <= (COUNT_W+1)'(QUEUE_DEPTH));
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_comb begin
		slot_d = slot_q;
		if (pop) begin
			slot_d[0] = slot_q[1];
		end
		if (advance) begin
			unique case (cnt_pop)
				COUNT_W'(0): begin
					slot_d[0] = ev0;
					slot_d[1] = ev1;
				end
				COUNT_W'(1): slot_d[1] = ev0;
				default: ;
			endcase
		end
		count_d = cnt_pop + (advance ? n_ev : COUNT_W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			stamp_q <= '0;
			timing_valid_q <= 1'b0;
			long_active_q <= 1'b0;
			count_q <= '0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
			count_q <= count_d;
			if (advance) begin
				stamp_q <= stamp_d;
				timing_valid_q <= timing_valid_d;
				long_active_q <= long_active_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			active_s1 <= sample_active;
			changed_s1 <= sample_changed;
			level_s1 <= button_level;
			now_s1 <= now_ticks;
		end
		slot_q <= slot_d;
	end

	assign event_target = slot_q[0].target;
	assign event_edge = slot_q[0].edge_kind;
	assign last_event = slot_q[0].last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(QUEUE_DEPTH))
		else $error("output queue overfilled");

	a_long_needs_timing: assert property (@(posedge clk) disable iff (!arst_n)
		long_active_q |-> timing_valid_q)
		else $error("long press active without a stamped press");

	a_empty_takes_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 && valid_s1) |-> !in_stall)
		else $error("sample held back with an empty output queue");

	a_stall_means_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && count_q != '0))
		else $error("input stalled with nothing pending");

	a_pair_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && n_ev == COUNT_W'(2) && count_d == COUNT_W'(2)) |=>
		(slot_q[1].last && !slot_q[0].last))
		else $error("two-event sample queued with wrong last marks");

endmodule
